@@ src/vdmx_pkg.sv @@
package vdmx_pkg;

  // default table store depth in bytes
  localparam int TABLE_BYTES_DEF = 4096;

  // offset and length widths
  localparam int OFF_W = 20;
  localparam int LEN_W = 17;

  // table layout
  localparam int NRATIO_OFF = 4;
  localparam int RATIO_BASE = 6;
  localparam int RATIO_REC  = 4;
  localparam int WORD_BYTES = 2;
  localparam int GROUP_HDR  = 4;
  localparam int ENTRY_REC  = 6;

  // input opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // register index taken from paddr[2]
  localparam logic REG_TABLE_BYTES = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NRATIO,
    S_RATIO_INIT,
    S_RATIO,
    S_RATIO_CHK,
    S_GOFF,
    S_GRP,
    S_GHDR,
    S_GHDR_CHK,
    S_ENT,
    S_ENT_CHK,
    S_FETCH,
    S_DONE
  } vdmx_state_t;

endpackage

@@ src/vdmx_pixel_size_lookup.sv @@
// VDMX pixel-size lookup. The font's VDMX table is loaded one byte per input beat
// (opcode write, no result); a lookup beat (opcode lookup) scans the ratio
// records for the first usable 1:1 or any-aspect group, then walks that group's
// entries to match a cell height (positive) or an em size (zero or negative), and
// returns exactly one result beat. The table store is a byte memory with one write
// port and one registered read port that delivers one byte per cycle, so the lookup
// time grows with each ratio record and group entry scanned; the input stays stalled
// meanwhile. The store needs no clearing after reset; bytes never written must not
// lie below table_bytes. table_bytes is written over the APB port at address 0.
module vdmx_pixel_size_lookup #(
  parameter int TABLE_BYTES = vdmx_pkg::TABLE_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [11:0]        in_byte_address,
  input  logic [7:0]         in_byte_value,
  input  logic signed [15:0] in_height,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_found,
  output logic [15:0]        out_pixel_size,
  output logic signed [15:0] out_ascent,
  output logic signed [16:0] out_descent,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import vdmx_pkg::*;

  localparam int AW = (TABLE_BYTES > 1) ? $clog2(TABLE_BYTES) : 1;
  localparam logic [LEN_W-1:0] DEPTH = LEN_W'(TABLE_BYTES);

  // state and datapath registers
  vdmx_state_t state_r, state_nxt;
  vdmx_state_t ret_r, ret_nxt;
  logic [12:0]        table_bytes_r;
  logic [OFF_W-1:0]   ptr_r, ptr_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic               pend_r, pend_nxt;
  logic [47:0]        sh_r, sh_nxt;
  logic [47:0]        prev_r, prev_nxt;
  logic               use_prev_r, use_prev_nxt;
  logic               hit_r, hit_nxt;
  logic [15:0]        lim_r, lim_nxt;
  logic [15:0]        idx_r, idx_nxt;
  logic [OFF_W-1:0]   roff_r, roff_nxt;
  logic [OFF_W-1:0]   gptr_r, gptr_nxt;
  logic [OFF_W-1:0]   eoff_r, eoff_nxt;
  logic [15:0]        grp_r, grp_nxt;
  logic signed [15:0] height_r, height_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [15:0]        out_size_r, out_size_nxt;
  logic signed [15:0] out_asc_r, out_asc_nxt;
  logic signed [16:0] out_desc_r, out_desc_nxt;

  // table store
  logic [7:0] mem [TABLE_BYTES];
  logic [7:0] rdata_r;
  logic       rd_en;
  logic       wr_en;
  logic [LEN_W-1:0] waddr_ext;

  // misc
  logic [LEN_W-1:0]   len;
  logic [OFF_W-1:0]   chk_off;
  logic [2:0]         chk_n;
  logic               fits;
  logic               in_acc;
  logic               h_pos;
  logic [16:0]        want;
  logic               ratio_hit;
  logic signed [17:0] cmp_a, cmp_b;
  logic               cmp_eq, cmp_gt;
  logic               want_out;
  logic               done_go;
  logic               idx_last;
  logic [47:0]        sel;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign waddr_ext = LEN_W'(in_byte_address);
  assign wr_en     = in_acc && (in_opcode == OP_WRITE) && (waddr_ext < DEPTH);
  assign rd_en     = (state_r == S_FETCH) && (cnt_r != 3'd0);

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr_ext[AW-1:0]] <= in_byte_value;
    end
    if (rd_en) begin
      rdata_r <= mem[ptr_r[AW-1:0]];
    end
  end

  // valid length, saturated to the store depth
  assign len = (LEN_W'(table_bytes_r) > DEPTH) ? DEPTH : LEN_W'(table_bytes_r);

  // shared bounds unit: does a read of chk_n bytes at chk_off stay inside len
  always_comb begin
    chk_off = '0;
    chk_n   = 3'd0;
    case (state_r)
      S_NRATIO: begin
        chk_off = OFF_W'(NRATIO_OFF);
        chk_n   = 3'(WORD_BYTES);
      end
      S_RATIO: begin
        chk_off = roff_r;
        chk_n   = 3'(RATIO_REC);
      end
      S_GOFF: begin
        chk_off = gptr_r;
        chk_n   = 3'(WORD_BYTES);
      end
      S_GHDR: begin
        chk_off = OFF_W'(grp_r);
        chk_n   = 3'(GROUP_HDR);
      end
      S_ENT: begin
        chk_off = eoff_r;
        chk_n   = 3'(ENTRY_REC);
      end
      default: begin
        chk_off = '0;
        chk_n   = 3'd0;
      end
    endcase
  end
  assign fits = ((OFF_W + 1)'(chk_off) + (OFF_W + 1)'(chk_n)) <= (OFF_W + 1)'(len);

  // height decode
  assign h_pos = !height_r[15] && (height_r != 16'sd0);
  assign want  = 17'(-{height_r[15], height_r});

  // ratio record match: nonzero charset, any aspect or covering 1:1
  assign ratio_hit = (sh_r[31:24] != 8'd0) &&
                     (((sh_r[23:16] == 8'd0) && (sh_r[15:8] == 8'd0) && (sh_r[7:0] == 8'd0)) ||
                      ((sh_r[23:16] == 8'd1) && (sh_r[15:8] <= 8'd1) && (sh_r[7:0] >= 8'd1)));

  // shared entry compare: cell height against yMax-yMin, or em size against size
  always_comb begin
    if (h_pos) begin
      cmp_a = 18'({{2{sh_r[31]}}, sh_r[31:16]}) - 18'({{2{sh_r[15]}}, sh_r[15:0]});
      cmp_b = 18'({{2{height_r[15]}}, height_r});
    end else begin
      cmp_a = 18'({2'b00, sh_r[47:32]});
      cmp_b = 18'({1'b0, want});
    end
  end
  assign cmp_eq = (cmp_a == cmp_b);
  assign cmp_gt = (cmp_a > cmp_b);

  // em size outside the group's size range
  assign want_out = (want < 17'(sh_r[15:8])) || (want > 17'(sh_r[7:0]));

  assign idx_last = (idx_r == lim_r);
  assign done_go  = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_opcode == OP_LOOKUP)) begin
          state_nxt = S_NRATIO;
        end
      end
      S_NRATIO: state_nxt = fits ? S_FETCH : S_DONE;
      S_FETCH: begin
        if ((cnt_r == 3'd0) && pend_r) begin
          state_nxt = ret_r;
        end
      end
      S_RATIO_INIT: state_nxt = S_RATIO;
      S_RATIO: state_nxt = (idx_last || !fits) ? S_DONE : S_FETCH;
      S_RATIO_CHK: state_nxt = ratio_hit ? S_GOFF : S_RATIO;
      S_GOFF: state_nxt = fits ? S_FETCH : S_DONE;
      S_GRP: state_nxt = (sh_r[15:0] == 16'd0) ? S_DONE : S_GHDR;
      S_GHDR: state_nxt = fits ? S_FETCH : S_DONE;
      S_GHDR_CHK: state_nxt = (!h_pos && want_out) ? S_DONE : S_ENT;
      S_ENT: state_nxt = (idx_last || !fits) ? S_DONE : S_FETCH;
      S_ENT_CHK: state_nxt = (cmp_eq || cmp_gt) ? S_DONE : S_ENT;
      S_DONE: begin
        if (done_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // chosen entry
  assign sel = use_prev_r ? prev_r : sh_r;

  // datapath and outputs
  always_comb begin
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    ret_nxt       = ret_r;
    sh_nxt        = sh_r;
    prev_nxt      = prev_r;
    use_prev_nxt  = use_prev_r;
    hit_nxt       = hit_r;
    lim_nxt       = lim_r;
    idx_nxt       = idx_r;
    roff_nxt      = roff_r;
    gptr_nxt      = gptr_r;
    eoff_nxt      = eoff_r;
    grp_nxt       = grp_r;
    height_nxt    = height_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_size_nxt  = out_size_r;
    out_asc_nxt   = out_asc_r;
    out_desc_nxt  = out_desc_r;

    // start a byte fetch from any checking state
    if ((state_nxt == S_FETCH) && (state_r != S_FETCH)) begin
      ptr_nxt = chk_off;
      cnt_nxt = chk_n;
    end

    case (state_r)
      S_IDLE: begin
        height_nxt   = in_height;
        hit_nxt      = 1'b0;
        use_prev_nxt = 1'b0;
      end
      S_NRATIO: ret_nxt = S_RATIO_INIT;
      S_FETCH: begin
        if (cnt_r != 3'd0) begin
          ptr_nxt  = ptr_r + OFF_W'(1);
          cnt_nxt  = cnt_r - 3'd1;
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          sh_nxt = {sh_r[39:0], rdata_r};
        end
      end
      S_RATIO_INIT: begin
        lim_nxt  = sh_r[15:0];
        idx_nxt  = 16'd0;
        roff_nxt = OFF_W'(RATIO_BASE);
        gptr_nxt = OFF_W'(RATIO_BASE) + OFF_W'({sh_r[15:0], 2'b00});
      end
      S_RATIO: ret_nxt = S_RATIO_CHK;
      S_RATIO_CHK: begin
        if (!ratio_hit) begin
          idx_nxt  = idx_r + 16'd1;
          roff_nxt = roff_r + OFF_W'(RATIO_REC);
          gptr_nxt = gptr_r + OFF_W'(WORD_BYTES);
        end
      end
      S_GOFF: ret_nxt = S_GRP;
      S_GRP: grp_nxt = sh_r[15:0];
      S_GHDR: ret_nxt = S_GHDR_CHK;
      S_GHDR_CHK: begin
        lim_nxt  = sh_r[31:16];
        idx_nxt  = 16'd0;
        eoff_nxt = OFF_W'(grp_r) + OFF_W'(GROUP_HDR);
      end
      S_ENT: ret_nxt = S_ENT_CHK;
      S_ENT_CHK: begin
        if (cmp_eq) begin
          hit_nxt = 1'b1;
        end else if (cmp_gt) begin
          // cell height past this entry takes the one before it
          if (h_pos && (idx_r != 16'd0)) begin
            hit_nxt      = 1'b1;
            use_prev_nxt = 1'b1;
          end
        end else begin
          prev_nxt = sh_r;
          idx_nxt  = idx_r + 16'd1;
          eoff_nxt = eoff_r + OFF_W'(ENTRY_REC);
        end
      end
      S_DONE: begin
        if (done_go) begin
          out_valid_nxt = 1'b1;
          if (hit_r && (sel[47:32] != 16'd0)) begin
            out_found_nxt = 1'b1;
            out_size_nxt  = sel[47:32];
            out_asc_nxt   = sel[31:16];
            out_desc_nxt  = 17'(-{sel[15], sel[15:0]});
          end else begin
            out_found_nxt = 1'b0;
            out_size_nxt  = 16'd0;
            out_asc_nxt   = 16'sd0;
            out_desc_nxt  = 17'sd0;
          end
        end
      end
      default: begin
        ret_nxt = ret_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= 3'd0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      table_bytes_r <= 13'd0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (psel && penable && pwrite && (paddr[2] == REG_TABLE_BYTES)) begin
        table_bytes_r <= pwdata[12:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ret_r       <= ret_nxt;
    ptr_r       <= ptr_nxt;
    sh_r        <= sh_nxt;
    prev_r      <= prev_nxt;
    use_prev_r  <= use_prev_nxt;
    hit_r       <= hit_nxt;
    lim_r       <= lim_nxt;
    idx_r       <= idx_nxt;
    roff_r      <= roff_nxt;
    gptr_r      <= gptr_nxt;
    eoff_r      <= eoff_nxt;
    grp_r       <= grp_nxt;
    height_r    <= height_nxt;
    out_found_r <= out_found_nxt;
    out_size_r  <= out_size_nxt;
    out_asc_r   <= out_asc_nxt;
    out_desc_r  <= out_desc_nxt;
  end

  // ports
  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_pixel_size = out_size_r;
  assign out_ascent     = out_asc_r;
  assign out_descent    = out_desc_r;
  assign pready         = 1'b1;
  assign prdata         = (paddr[2] == REG_TABLE_BYTES) ? {19'd0, table_bytes_r} : 32'd0;

`ifndef SYNTHESIS
  // a lookup beat leaves idle on the next cycle
  a_lookup_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_opcode == OP_LOOKUP)) |=> (state_r != S_IDLE))
    else $error("lookup beat did not start the sequencer");

  // store reads stay inside the valid table length
  a_read_in_len: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (LEN_W'(ptr_r) < len))
    else $error("table read beyond valid length");

  // a miss beat carries zero payload
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |->
      ((out_pixel_size == 16'd0) && (out_ascent == 16'sd0) && (out_descent == 17'sd0)))
    else $error("miss beat with nonzero payload");

  // fetch never asks for more than one entry record
  a_fetch_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH) |-> (cnt_r <= 3'(ENTRY_REC)))
    else $error("fetch byte count out of range");
`endif

endmodule
